[rtl/core/sobel_gradient_magnitude_assert.svh]
// ---------------------------------------------------------------------------
// Sobel gradient magnitude assertion macros
// Shared concurrent assertion forms used by the port checker
// ---------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_MAGNITUDE_ASSERT_SVH
`define SOBEL_GRADIENT_MAGNITUDE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SGM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgm assertion failed");

// next-cycle implication, disabled during reset
`define SGM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgm assertion failed");

`endif

[rtl/core/sgm_pkg.sv]
// ---------------------------------------------------------------------------
// sgm_pkg
// Shared widths, constants, register codes and pipeline types
// ---------------------------------------------------------------------------
package sgm_pkg;

    localparam int SGM_MAX_WIDTH       = 2048;
    localparam int PADDED_WIDTH_RESET  = 2048;
    localparam int PADDED_HEIGHT_RESET = 4096;
    localparam int HEIGHT_LIMIT        = 4096;
    localparam int MIN_PADDED          = 3;

    localparam int PIX_W        = 8;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;
    localparam int ROW_W        = 12;
    localparam int GRAD_W       = 11;
    localparam int SQ_W         = 20;
    localparam int SUM_W        = 21;
    localparam int POS_W        = 5;
    localparam int EXP_W        = 8;
    localparam int MANT_W       = 23;
    localparam int EXP_BIAS     = 127;
    localparam int BITS_W       = 32;
    localparam int FIFO_DEPTH   = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PADDED_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_PADDED_HEIGHT = CFG_INDEX_W'(1);

    // square-root approximation on the single bit pattern
    localparam logic [BITS_W-1:0] ROOT_BIAS = BITS_W'(1 << 29);
    localparam logic [BITS_W-1:0] ROOT_CORR = BITS_W'(1 << 22);

    // window taps for one pixel, leaving the line buffer
    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             eol;
        logic             eof;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } sgm_tap_t;

    // sum of squares with its marks
    typedef struct packed {
        logic             valid;
        logic             eol;
        logic             eof;
        logic [SUM_W-1:0] sum;
    } sgm_sum_t;

    // finished result word
    typedef struct packed {
        logic              valid;
        logic              eol;
        logic              eof;
        logic [BITS_W-1:0] bits;
    } sgm_res_t;

endpackage

[rtl/core/sgm_if.sv]
// ---------------------------------------------------------------------------
// sgm_if
// Valid/ready stream interfaces for pixels in and magnitude words out
// ---------------------------------------------------------------------------
interface sgm_pixel_if;
    import sgm_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             start_of_frame;

    modport source (output valid, output pixel, output start_of_frame, input ready);
    modport sink   (input valid, input pixel, input start_of_frame, output ready);
endinterface

interface sgm_mag_if;
    import sgm_pkg::*;

    logic              valid;
    logic              ready;
    logic [BITS_W-1:0] magnitude_bits;
    logic              end_of_line;
    logic              end_of_frame;

    modport source (output valid, output magnitude_bits, output end_of_line,
                    output end_of_frame, input ready);
    modport sink   (input valid, input magnitude_bits, input end_of_line,
                    input end_of_frame, output ready);
endinterface

[rtl/core/sgm_line_buffer.sv]
// ---------------------------------------------------------------------------
// sgm_line_buffer
// Row/column counters and the two-row line store with write-back forwarding
// ---------------------------------------------------------------------------
module sgm_line_buffer #(
    parameter int MAX_WIDTH = sgm_pkg::SGM_MAX_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [sgm_pkg::PIX_W-1:0]          pixel,
    input  logic                               start_of_frame,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]     last_col,
    input  logic [sgm_pkg::ROW_W-1:0]          last_row,
    output logic                               emit_now,
    output sgm_pkg::sgm_tap_t                  tap
);
    import sgm_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [AW-1:0]      col_reg, col_next, col_cur;
    logic [ROW_W-1:0]   row_reg, row_next, row_cur;
    logic               is_last_col, is_last_row;

    // one entry holds {upper row, middle row}
    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;
    logic [2*PIX_W-1:0] fwd_reg;
    logic [2*PIX_W-1:0] eff_data;
    logic               hit_reg;

    logic               s1_valid_reg;
    logic               s1_emit_reg;
    logic               s1_eol_reg;
    logic               s1_eof_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic [PIX_W-1:0]   s1_pix_reg;

    // position of the pixel being offered
    always_comb
    begin
        col_cur     = start_of_frame ? '0 : col_reg;
        row_cur     = start_of_frame ? '0 : row_reg;
        is_last_col = WW'(col_cur) >= last_col;
        is_last_row = row_cur >= last_row;
        emit_now    = (row_cur >= ROW_W'(2)) && (col_cur >= AW'(2));
        if (is_last_col)
        begin
            col_next = '0;
            row_next = is_last_row ? '0 : row_cur + ROW_W'(1);
        end
        else
        begin
            col_next = col_cur + AW'(1);
            row_next = row_cur;
        end
    end

    // counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            hit_reg      <= accept && s1_valid_reg && (s1_addr_reg == col_cur);
        end
    end

    // stage one payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= col_cur;
            s1_pix_reg  <= pixel;
            s1_emit_reg <= emit_now;
            s1_eol_reg  <= is_last_col;
            s1_eof_reg  <= is_last_col && is_last_row;
        end
        if (s1_valid_reg)
        begin
            fwd_reg <= {eff_data[PIX_W-1:0], s1_pix_reg};
        end
    end

    // line store: read on accept, written back in the following cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= mem[col_cur];
        end
        if (s1_valid_reg)
        begin
            mem[s1_addr_reg] <= {eff_data[PIX_W-1:0], s1_pix_reg};
        end
    end

    // back-to-back access to one column takes the value just written
    assign eff_data = hit_reg ? fwd_reg : rd_data_reg;

    always_comb
    begin
        tap.valid = s1_valid_reg;
        tap.emit  = s1_emit_reg;
        tap.eol   = s1_eol_reg;
        tap.eof   = s1_eof_reg;
        tap.top   = eff_data[2*PIX_W-1:PIX_W];
        tap.mid   = eff_data[PIX_W-1:0];
        tap.bot   = s1_pix_reg;
    end
endmodule

[rtl/core/sgm_gradient.sv]
// ---------------------------------------------------------------------------
// sgm_gradient
// 3x3 window, Sobel Gx/Gy, squares and their sum over three stages
// ---------------------------------------------------------------------------
module sgm_gradient (
    input  logic              clk,
    input  logic              rst_n,
    input  sgm_pkg::sgm_tap_t tap,
    output sgm_pkg::sgm_sum_t sum_out
);
    import sgm_pkg::*;

    // [0..2] older column top/mid/bot, [3..5] newer column
    logic [PIX_W-1:0]         win_reg [6];

    logic signed [GRAD_W-1:0] t0, m0, b0, t1, b1, t2, m2, b2;
    logic signed [GRAD_W-1:0] gx, gy;

    logic                     g_valid_reg, g_eol_reg, g_eof_reg;
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic                     q_valid_reg, q_eol_reg, q_eof_reg;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;
    logic signed [2*GRAD_W-1:0] px, py;
    logic                     s_valid_reg, s_eol_reg, s_eof_reg;
    logic [SUM_W-1:0]         sum_reg;

    function automatic logic signed [GRAD_W-1:0] widen(input logic [PIX_W-1:0] v);
        return $signed(GRAD_W'(v));
    endfunction

    // sobel kernels
    always_comb
    begin
        t0 = widen(win_reg[0]);
        m0 = widen(win_reg[1]);
        b0 = widen(win_reg[2]);
        t1 = widen(win_reg[3]);
        b1 = widen(win_reg[5]);
        t2 = widen(tap.top);
        m2 = widen(tap.mid);
        b2 = widen(tap.bot);
        gx = t0 - t2 + (m0 <<< 1) - (m2 <<< 1) + b0 - b2;
        gy = t0 + (t1 <<< 1) + t2 - b0 - (b1 <<< 1) - b2;
    end

    // window shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (tap.valid)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= tap.top;
            win_reg[4] <= tap.mid;
            win_reg[5] <= tap.bot;
        end
    end

    // products
    assign px = gx_reg * gx_reg;
    assign py = gy_reg * gy_reg;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            g_valid_reg <= tap.valid && tap.emit;
            q_valid_reg <= g_valid_reg;
            s_valid_reg <= q_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        gx_reg    <= gx;
        gy_reg    <= gy;
        g_eol_reg <= tap.eol;
        g_eof_reg <= tap.eof;
        sqx_reg   <= px[SQ_W-1:0];
        sqy_reg   <= py[SQ_W-1:0];
        q_eol_reg <= g_eol_reg;
        q_eof_reg <= g_eof_reg;
        sum_reg   <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
        s_eol_reg <= q_eol_reg;
        s_eof_reg <= q_eof_reg;
    end

    always_comb
    begin
        sum_out.valid = s_valid_reg;
        sum_out.eol   = s_eol_reg;
        sum_out.eof   = s_eof_reg;
        sum_out.sum   = sum_reg;
    end
endmodule

[rtl/core/sgm_float_root.sv]
// ---------------------------------------------------------------------------
// sgm_float_root
// Exact integer to single conversion and shift-subtract root approximation
// ---------------------------------------------------------------------------
module sgm_float_root (
    input  logic              clk,
    input  logic              rst_n,
    input  sgm_pkg::sgm_sum_t sum_in,
    output sgm_pkg::sgm_res_t res
);
    import sgm_pkg::*;

    logic [POS_W-1:0]          pos;
    logic                      n_valid_reg, n_eol_reg, n_eof_reg;
    logic [POS_W-1:0]          pos_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [MANT_W+SUM_W-1:0]   shifted;
    logic [EXP_W-1:0]          expo;
    logic [BITS_W-1:0]         single;

    // leading one position
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < SUM_W; i++)
        begin
            if (sum_in.sum[i])
            begin
                pos = POS_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_valid_reg <= 1'b0;
        end
        else
        begin
            n_valid_reg <= sum_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos;
        sum_reg   <= sum_in.sum;
        n_eol_reg <= sum_in.eol;
        n_eof_reg <= sum_in.eof;
    end

    // normalize, pack and approximate the root
    always_comb
    begin
        shifted = (MANT_W+SUM_W)'(sum_reg) << (POS_W'(MANT_W) - pos_reg);
        expo    = EXP_W'(EXP_BIAS) + EXP_W'(pos_reg);
        if (sum_reg == '0)
        begin
            single = '0;
        end
        else
        begin
            single = {1'b0, expo, shifted[MANT_W-1:0]};
        end
        res.valid = n_valid_reg;
        res.eol   = n_eol_reg;
        res.eof   = n_eof_reg;
        res.bits  = ROOT_BIAS + {1'b0, single[BITS_W-1:1]} - ROOT_CORR;
    end
endmodule

[rtl/core/sgm_out_fifo.sv]
// ---------------------------------------------------------------------------
// sgm_out_fifo
// Output word queue with credit count covering words still in the pipeline
// ---------------------------------------------------------------------------
module sgm_out_fifo #(
    parameter int DEPTH = sgm_pkg::FIFO_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       reserve,
    output logic                       has_room,
    input  sgm_pkg::sgm_res_t          wr,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [sgm_pkg::BITS_W-1:0] out_bits,
    output logic                       out_eol,
    output logic                       out_eof
);
    import sgm_pkg::*;

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [BITS_W+1:0] entry [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0]   count_reg, count_next;
    logic [CNTW-1:0]   credit_reg, credit_next;
    logic              pop;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign has_room  = credit_reg < CNTW'(DEPTH);
    assign out_bits  = entry[rd_ptr_reg][BITS_W-1:0];
    assign out_eol   = entry[rd_ptr_reg][BITS_W];
    assign out_eof   = entry[rd_ptr_reg][BITS_W+1];

    // occupancy and outstanding credit
    always_comb
    begin
        count_next  = count_reg + CNTW'(wr.valid) - CNTW'(pop);
        credit_next = credit_reg + CNTW'(reserve) - CNTW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            credit_reg <= credit_next;
            if (wr.valid)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (wr.valid)
        begin
            entry[wr_ptr_reg] <= {wr.eof, wr.eol, wr.bits};
        end
    end
endmodule

[rtl/core/sobel_gradient_magnitude.sv]
// ---------------------------------------------------------------------------
// sobel_gradient_magnitude
// Streaming 3x3 Sobel gradient magnitude with single-float root approximation
// ---------------------------------------------------------------------------
// A word passes the line-buffer, Sobel, square, sum and root registers, then the output queue.
// Throughput: one pixel per cycle while ready is high; the line store reads one column and writes it back.
// Ready drops only while eight words are outstanding in the pipeline and the eight-entry output queue.
// Reset clears counters, window, pipeline and queue; size registers return to 2048 x 4096.
// The line store is not cleared and needs no clearing pass.
module sobel_gradient_magnitude #(
    parameter int MAX_WIDTH = sgm_pkg::SGM_MAX_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    sgm_pixel_if.sink                      pixel_stream,
    sgm_mag_if.source                      magnitude_stream,
    input  logic                           cfg_write,
    input  logic [sgm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sgm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sgm_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
    localparam int WIDTH_RESET_EFF =
        (PADDED_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : PADDED_WIDTH_RESET;

    logic [WW-1:0]           last_col_reg, last_col_next;
    logic [ROW_W-1:0]        last_row_reg, last_row_next;
    logic [CMP_W-1:0]        w_raw, w_eff;
    logic [HEIGHT_REG_W-1:0] h_raw, h_eff;

    logic                    accept;
    logic                    emit_now;
    logic                    has_room;
    sgm_tap_t                tap;
    sgm_sum_t                sum;
    sgm_res_t                res;

    // size registers, kept as last column and last row index
    always_comb
    begin
        w_raw = CMP_W'(cfg_data[WIDTH_REG_W-1:0]);
        h_raw = cfg_data[HEIGHT_REG_W-1:0];
        if (w_raw < CMP_W'(MIN_PADDED))
        begin
            w_eff = CMP_W'(MIN_PADDED);
        end
        else if (w_raw > CMP_W'(MAX_WIDTH))
        begin
            w_eff = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_raw;
        end
        if (h_raw < HEIGHT_REG_W'(MIN_PADDED))
        begin
            h_eff = HEIGHT_REG_W'(MIN_PADDED);
        end
        else if (h_raw > HEIGHT_REG_W'(HEIGHT_LIMIT))
        begin
            h_eff = HEIGHT_REG_W'(HEIGHT_LIMIT);
        end
        else
        begin
            h_eff = h_raw;
        end
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_PADDED_WIDTH:  last_col_next = WW'(w_eff - CMP_W'(1));
                REG_PADDED_HEIGHT: last_row_next = ROW_W'(h_eff - HEIGHT_REG_W'(1));
                default:           last_col_next = last_col_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= WW'(WIDTH_RESET_EFF - 1);
            last_row_reg <= ROW_W'(PADDED_HEIGHT_RESET - 1);
        end
        else
        begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
        end
    end

    // input handshake
    assign pixel_stream.ready = has_room;
    assign accept             = pixel_stream.valid && has_room;

    sgm_line_buffer #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buffer (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .pixel          (pixel_stream.pixel),
        .start_of_frame (pixel_stream.start_of_frame),
        .last_col       (last_col_reg),
        .last_row       (last_row_reg),
        .emit_now       (emit_now),
        .tap            (tap)
    );

    sgm_gradient u_gradient (
        .clk     (clk),
        .rst_n   (rst_n),
        .tap     (tap),
        .sum_out (sum)
    );

    sgm_float_root u_float_root (
        .clk    (clk),
        .rst_n  (rst_n),
        .sum_in (sum),
        .res    (res)
    );

    sgm_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .reserve   (accept && emit_now),
        .has_room  (has_room),
        .wr        (res),
        .out_ready (magnitude_stream.ready),
        .out_valid (magnitude_stream.valid),
        .out_bits  (magnitude_stream.magnitude_bits),
        .out_eol   (magnitude_stream.end_of_line),
        .out_eof   (magnitude_stream.end_of_frame)
    );
endmodule

[rtl/core/sgm_checker.sv]
// ---------------------------------------------------------------------------
// sgm_checker
// Port-level checks on stream ordering, latency and back-pressure
// ---------------------------------------------------------------------------
`include "sobel_gradient_magnitude_assert.svh"

module sgm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [sgm_pkg::BITS_W-1:0] out_bits,
    input logic                       out_eol,
    input logic                       out_eof
);
    // frame end always closes a line
    `SGM_ASSERT_IMPLIES(a_eof_has_eol, clk, rst_n, out_valid && out_eof, out_eol)

    // a word appearing on an empty queue traces back to a pixel that was taken at the input
    `SGM_ASSERT_IMPLIES(a_first_word_latency, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 6))

    // input is held back only while words wait at the output
    `SGM_ASSERT_IMPLIES(a_stall_needs_backlog, clk, rst_n, !in_ready, out_valid)

    // a stalled word holds
    `SGM_ASSERT_NEXT(a_word_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bits) && $stable(out_eol) && $stable(out_eof))
endmodule

bind sobel_gradient_magnitude sgm_checker u_sgm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel_stream.valid),
    .in_ready  (pixel_stream.ready),
    .out_valid (magnitude_stream.valid),
    .out_ready (magnitude_stream.ready),
    .out_bits  (magnitude_stream.magnitude_bits),
    .out_eol   (magnitude_stream.end_of_line),
    .out_eof   (magnitude_stream.end_of_frame)
);

[verif/sobel_gradient_magnitude_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sobel_gradient_magnitude_test
// Drives padded pixel frames into the Sobel magnitude block and compares
// every magnitude word against an in-bench model of the line stores, the
// 3x3 window, the single-float conversion and the root approximation.
// ---------------------------------------------------------------------------
module sobel_gradient_magnitude_test;
    import sgm_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int PIPE_SETTLE  = 12;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_LIMIT = 10;

    localparam logic [BITS_W-1:0] HALF_EXP_OFFSET = 32'h2000_0000;
    localparam logic [BITS_W-1:0] ROOT_TRIM       = 32'h0040_0000;

    typedef struct packed {
        logic [BITS_W-1:0] bits;
        logic              eol;
        logic              eof;
    } magnitude_word_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sgm_pixel_if pix_if ();
    sgm_mag_if   mag_if ();

    sobel_gradient_magnitude u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .pixel_stream     (pix_if),
        .magnitude_stream (mag_if),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // model state
    logic [PIX_W-1:0] upper_row [SGM_MAX_WIDTH];
    logic [PIX_W-1:0] middle_row [SGM_MAX_WIDTH];
    logic [PIX_W-1:0] window_px [6];
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      width_reg;
    int unsigned      height_reg;

    magnitude_word_t pending_magnitudes [$];

    int fail_count        = 0;
    int quiet_cycles      = 0;
    int sender_idle_pct   = 29;
    int receiver_idle_pct = 54;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // exact integer to single-precision bit pattern
    function automatic logic [BITS_W-1:0] single_from_sum(int unsigned sum);
        logic [31:0] s;
        logic [31:0] frac;
        int          msb;
        int          i;
        s   = sum;
        msb = 0;
        if (s == 0)
        begin
            return '0;
        end
        for (i = 0; i < 32; i++)
        begin
            if (s[i])
            begin
                msb = i;
            end
        end
        frac = s << (23 - msb);
        return {1'b0, 8'(127 + msb), frac[22:0]};
    endfunction

    // shift-and-subtract root on the float pattern, wraps mod 2^32
    function automatic logic [BITS_W-1:0] approx_root(logic [BITS_W-1:0] b);
        return HALF_EXP_OFFSET + (b >> 1) - ROOT_TRIM;
    endfunction

    function automatic void reset_model();
        int i;
        for (i = 0; i < SGM_MAX_WIDTH; i++)
        begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        for (i = 0; i < 6; i++)
        begin
            window_px[i] = '0;
        end
        col_pos    = 0;
        row_pos    = 0;
        width_reg  = PADDED_WIDTH_RESET;
        height_reg = PADDED_HEIGHT_RESET;
    endfunction

    // advance the window by one pixel and queue the word it produces, if any
    function automatic void predict_magnitude(logic [PIX_W-1:0] px, logic sof);
        int unsigned     w;
        int unsigned     h;
        int unsigned     c;
        int unsigned     r;
        int unsigned     idx;
        int              t0, m0, b0, t1, b1, t2, m2, b2, gx, gy;
        int unsigned     sq;
        logic [PIX_W-1:0] top_px;
        logic [PIX_W-1:0] mid_px;
        logic            last_col;
        logic            last_row;
        magnitude_word_t word;

        w = width_reg;
        if (w < MIN_PADDED) w = MIN_PADDED;
        if (w > SGM_MAX_WIDTH) w = SGM_MAX_WIDTH;
        h = height_reg;
        if (h < MIN_PADDED) h = MIN_PADDED;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;

        if (sof)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c   = col_pos;
        r   = row_pos;
        idx = (c < SGM_MAX_WIDTH) ? c : SGM_MAX_WIDTH - 1;

        // line stores roll down one row
        top_px          = upper_row[idx];
        mid_px          = middle_row[idx];
        upper_row[idx]  = mid_px;
        middle_row[idx] = px;

        last_col = (c >= w - 1);
        last_row = (r >= h - 1);

        if (r >= 2 && c >= 2)
        begin
            t0 = window_px[0];
            m0 = window_px[1];
            b0 = window_px[2];
            t1 = window_px[3];
            b1 = window_px[5];
            t2 = top_px;
            m2 = mid_px;
            b2 = px;
            gx = t0 - t2 + 2 * m0 - 2 * m2 + b0 - b2;
            gy = t0 + 2 * t1 + t2 - b0 - 2 * b1 - b2;
            sq = gx * gx + gy * gy;
            word.bits = approx_root(single_from_sum(sq));
            word.eol  = last_col;
            word.eof  = last_col && last_row;
            pending_magnitudes.push_back(word);
        end

        window_px[0] = window_px[3];
        window_px[1] = window_px[4];
        window_px[2] = window_px[5];
        window_px[3] = top_px;
        window_px[4] = mid_px;
        window_px[5] = px;

        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endfunction

    // send one pixel word, with random gaps before it
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic sof);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            pix_if.valid = 1'b0;
            @(negedge clk);
        end
        pix_if.valid          = 1'b1;
        pix_if.pixel          = px;
        pix_if.start_of_frame = sof;
        do
        begin
            @(posedge clk);
        end
        while (!pix_if.ready);
        predict_magnitude(px, sof);
        @(negedge clk);
    endtask

    // stop sending and let the pipeline and output queue run dry
    task automatic wait_for_idle();
        pix_if.valid = 1'b0;
        while (pending_magnitudes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (PIPE_SETTLE) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_write = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        if (index == REG_PADDED_WIDTH)
        begin
            width_reg = data[WIDTH_REG_W-1:0];
        end
        else
        begin
            height_reg = data[HEIGHT_REG_W-1:0];
        end
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] wdata,
                                input logic [CFG_DATA_W-1:0] hdata);
        wait_for_idle();
        write_register(REG_PADDED_WIDTH, wdata);
        write_register(REG_PADDED_HEIGHT, hdata);
    endtask

    task automatic send_random_pixels(input int unsigned count, input logic sof_first);
        int unsigned i;
        for (i = 0; i < count; i++)
        begin
            send_pixel(8'($urandom_range(0, 255)), sof_first && i == 0);
        end
    endtask

    // reset geometry is 2048 x 4096: a long first row, then a narrower width
    // ends it and rows one and two follow without a frame end
    task automatic test_reset_geometry();
        send_random_pixels(40, 1'b1);
        wait_for_idle();
        write_register(REG_PADDED_WIDTH, 13'd5);
        send_random_pixels(1 + 5 + 5, 1'b0);
    endtask

    // flat frame and checkerboard both give zero gradient at every window
    task automatic test_flat_and_checker();
        int r;
        int c;
        set_geometry(13'd3, 13'd3);
        for (r = 0; r < 9; r++)
        begin
            send_pixel(8'hFF, r == 0);
        end
        set_geometry(13'd4, 13'd4);
        for (r = 0; r < 4; r++)
        begin
            for (c = 0; c < 4; c++)
            begin
                send_pixel(((r ^ c) & 1) ? 8'hFF : 8'h00, r == 0 && c == 0);
            end
        end
    endtask

    // sizes below three and above the limits are clamped, upper width bit dropped
    task automatic test_register_clamping();
        set_geometry(13'd0, 13'd1);
        send_random_pixels(9, 1'b1);
        set_geometry(13'd2, 13'd2);
        send_random_pixels(9, 1'b1);
        // oversized width gives a long first row, closed by a narrower width
        set_geometry(13'h1FFF, 13'd3);
        send_random_pixels(40, 1'b1);
        wait_for_idle();
        write_register(REG_PADDED_WIDTH, 13'd5);
        send_random_pixels(1 + 5 + 5, 1'b0);
        // oversized height never ends the frame early
        set_geometry(13'h1003, 13'h1FFF);
        send_random_pixels(3 * 6, 1'b1);
    endtask

    // width and height shrunk while the counters sit past the new limits
    task automatic test_shrink_mid_frame();
        set_geometry(13'd8, 13'd8);
        send_random_pixels(2 * 8 + 6, 1'b1);
        wait_for_idle();
        write_register(REG_PADDED_WIDTH, 13'd4);
        send_random_pixels(1 + 4 + 2, 1'b0);
        wait_for_idle();
        write_register(REG_PADDED_HEIGHT, 13'd4);
        send_random_pixels(2, 1'b0);
        // next frame follows without a start mark
        send_random_pixels(16, 1'b0);
    endtask

    // start mark in the middle of a frame, then a frame that wraps on its own
    task automatic test_frame_restarts();
        set_geometry(13'd5, 13'd4);
        send_random_pixels(12, 1'b1);
        send_random_pixels(20, 1'b1);
        send_random_pixels(24, 1'b0);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b1);
        send_random_pixels(19, 1'b0);
    endtask

    // random small frames with random content and occasional broken framing
    task automatic test_random_frames(input int unsigned item_goal);
        int unsigned      sent;
        int unsigned      w_eff;
        int unsigned      h_eff;
        int unsigned      frames;
        int unsigned      f;
        int unsigned      i;
        int unsigned      n_px;
        int unsigned      kind;
        int unsigned      style;
        logic [PIX_W-1:0] base;
        logic [PIX_W-1:0] px;
        logic [CFG_DATA_W-1:0] wdata;
        logic [CFG_DATA_W-1:0] hdata;
        sent = 0;
        while (sent < item_goal)
        begin
            wdata = 13'($urandom_range(3, 12));
            hdata = 13'($urandom_range(3, 8));
            case ($urandom_range(0, 9))
                0: wdata = 13'($urandom_range(0, 2));
                1: wdata = {1'b1, wdata[11:0]};
                2: hdata = 13'($urandom_range(0, 2));
                default: ;
            endcase
            set_geometry(wdata, hdata);
            w_eff = (wdata[11:0] < MIN_PADDED) ? MIN_PADDED : wdata[11:0];
            h_eff = (hdata < MIN_PADDED) ? MIN_PADDED : hdata;
            frames = $urandom_range(1, 3);
            for (f = 0; f < frames; f++)
            begin
                n_px = w_eff * h_eff;
                kind = $urandom_range(0, 9);
                // cut short so the next frame restarts mid-way
                if (kind == 0)
                begin
                    n_px = $urandom_range(1, n_px - 1);
                end
                style = $urandom_range(0, 3);
                base  = 8'($urandom_range(0, 255));
                for (i = 0; i < n_px; i++)
                begin
                    case (style)
                        0: px = 8'($urandom_range(0, 255));
                        1: px = base;
                        2: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                        default: px = 8'(base + i * 3 + $urandom_range(0, 7));
                    endcase
                    send_pixel(px, i == 0 && (f == 0 || kind != 1));
                end
                sent += n_px;
            end
        end
    endtask

    task automatic finish_run();
        wait_for_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_magnitudes.size() != 0)
        begin
            fail_count += pending_magnitudes.size();
            $display("%0d expected words never arrived", pending_magnitudes.size());
        end
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    endtask

    // output ready, random per cycle
    initial
    begin
        mag_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            mag_if.ready = ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // compare each accepted word with the oldest expectation
    always @(posedge clk)
    begin : word_check
        magnitude_word_t want;
        if (rst_n && mag_if.valid && mag_if.ready)
        begin
            if (pending_magnitudes.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                begin
                    $display("unexpected word: bits %h eol %b eof %b",
                             mag_if.magnitude_bits, mag_if.end_of_line, mag_if.end_of_frame);
                end
            end
            else
            begin
                want = pending_magnitudes.pop_front();
                if (mag_if.magnitude_bits !== want.bits || mag_if.end_of_line !== want.eol
                    || mag_if.end_of_frame !== want.eof)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("word mismatch: expected %h eol %b eof %b, got %h eol %b eof %b",
                                 want.bits, want.eol, want.eof, mag_if.magnitude_bits,
                                 mag_if.end_of_line, mag_if.end_of_frame);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((pix_if.valid && pix_if.ready) || (mag_if.valid && mag_if.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("no word moved for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        rst_n                 = 1'b0;
        pix_if.valid          = 1'b0;
        pix_if.pixel          = '0;
        pix_if.start_of_frame = 1'b0;
        cfg_write             = 1'b0;
        cfg_index             = REG_PADDED_WIDTH;
        cfg_data              = '0;
        reset_model();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_reset_geometry();
        test_flat_and_checker();
        test_register_clamping();
        test_shrink_mid_frame();
        test_frame_restarts();
        test_random_frames(400);

        sender_idle_pct   = 54;
        receiver_idle_pct = 29;
        test_random_frames(400);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_frames(400);

        finish_run();
    end

endmodule
